/* rtl/twd_pkg.sv */
// shared types, constants and conversion function for the tensor weight dequantizer
`default_nettype none
package twd_pkg;

  typedef enum logic [1:0] {
    FMT_F32 = 2'd0,
    FMT_F16 = 2'd1,
    FMT_Q80 = 2'd2,
    FMT_NONE = 2'd3
  } fmt_t;

  localparam int unsigned Q8BlockBytes = 34;
  localparam logic [31:0] ExpAllOnes = 32'h7F80_0000;
  localparam logic [31:0] QNanInf0 = 32'hFFC0_0000;
  localparam logic [7:0] ExpBiasDiff = 8'd112;

  // operation handed from the front end to the datapath stage
  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_HALF = 2'd1,
    OP_SCALE = 2'd2
  } op_t;

  typedef struct packed {
    op_t op;
    logic [31:0] data;
    logic [15:0] scale;
  } work_t;

  // binary16 to binary32, exact
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] lz;
    logic [9:0] mn;
    logic [31:0] r;
    e = h[14:10];
    m = h[9:0];
    lz = 4'd0;
    for (int i = 9; i >= 0; i--) begin
      if (m[i] && lz == 4'd0) lz = 4'(10 - i);
    end
    mn = 10'(m << lz);
    if (e == 5'd0) begin
      if (m == 10'd0) r = {h[15], 31'd0};
      else r = {h[15], 8'(ExpBiasDiff + 8'd1 - 8'(lz)), mn, 13'd0};
    end else if (e == 5'h1F) begin
      r = {h[15], 8'hFF, m, 13'd0};
    end else begin
      r = {h[15], 8'(8'(e) + ExpBiasDiff), m, 13'd0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/twd_front.sv */
// byte gathering and position tracking for the dequantizer
`default_nettype none
module twd_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [1:0] element_format,
  input  wire logic take,
  input  wire logic [7:0] data_byte,
  input  wire logic tensor_start,
  output logic emit,
  output twd_pkg::work_t work
);
  logic [5:0] byte_position, byte_position_next;
  logic [23:0] partial_bytes, partial_bytes_next;
  logic [15:0] block_scale, block_scale_next;
  logic [5:0] pos;

  always_comb begin
    pos = tensor_start ? 6'd0 : byte_position;
    byte_position_next = pos;
    partial_bytes_next = partial_bytes;
    block_scale_next = block_scale;
    emit = 1'b0;
    work.op = twd_pkg::OP_PASS;
    work.data = {data_byte, partial_bytes};
    work.scale = block_scale;
    unique case (twd_pkg::fmt_t'(element_format))
      twd_pkg::FMT_F32: begin
        if (pos >= 6'd4) pos = 6'd0;
        if (pos < 6'd3) begin
          if (pos == 6'd0) partial_bytes_next = {16'd0, data_byte};
          else if (pos == 6'd1) partial_bytes_next[15:8] = data_byte;
          else partial_bytes_next[23:16] = data_byte;
          byte_position_next = pos + 6'd1;
        end else begin
          emit = 1'b1;
          byte_position_next = 6'd0;
        end
      end
      twd_pkg::FMT_F16: begin
        if (pos >= 6'd2) pos = 6'd0;
        work.op = twd_pkg::OP_HALF;
        work.data = {16'd0, data_byte, partial_bytes[7:0]};
        if (pos == 6'd0) begin
          partial_bytes_next = {16'd0, data_byte};
          byte_position_next = 6'd1;
        end else begin
          emit = 1'b1;
          byte_position_next = 6'd0;
        end
      end
      twd_pkg::FMT_Q80: begin
        if (pos >= 6'(twd_pkg::Q8BlockBytes)) pos = 6'd0;
        work.op = twd_pkg::OP_SCALE;
        work.data = {24'd0, data_byte};
        if (pos == 6'd0) begin
          partial_bytes_next = {16'd0, data_byte};
          byte_position_next = 6'd1;
        end else if (pos == 6'd1) begin
          block_scale_next = {data_byte, partial_bytes[7:0]};
          byte_position_next = 6'd2;
        end else begin
          emit = 1'b1;
          byte_position_next = (pos + 6'd1 >= 6'(twd_pkg::Q8BlockBytes)) ? 6'd0 : pos + 6'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      partial_bytes <= '0;
      block_scale <= '0;
    end else if (take) begin
      byte_position <= byte_position_next;
      partial_bytes <= partial_bytes_next;
      block_scale <= block_scale_next;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position < 6'(twd_pkg::Q8BlockBytes)) else $error("position out of range");
  a_scale_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(take) |-> $stable(block_scale)) else $error("scale changed without a word");
  a_emit_fmt: assert property (@(posedge clk) disable iff (rst)
    element_format == twd_pkg::FMT_NONE |-> !emit) else $error("result on unused format");
`endif
endmodule
`default_nettype wire

/* rtl/twd_math.sv */
// binary16 widening and scale times signed byte product
`default_nettype none
module twd_math (
  input  wire twd_pkg::work_t work,
  output logic [31:0] value
);
  logic [31:0] f;
  logic qneg;
  logic [7:0] qmag;
  logic sgn;
  logic [7:0] e;
  logic [31:0] p;
  logic [3:0] msb;
  logic [31:0] pn;

  always_comb begin
    f = twd_pkg::half_to_single(work.op == twd_pkg::OP_HALF ? work.data[15:0] : work.scale);
    qneg = work.data[7];
    qmag = qneg ? 8'(9'd256 - {1'b0, work.data[7:0]}) : work.data[7:0];
    sgn = f[31] ^ qneg;
    e = f[30:23];
    p = {24'd0, qmag} * {8'd0, 1'b1, f[22:0]};
    msb = 4'd0;
    for (int i = 31; i >= 24; i--) begin
      if (p[i] && msb == 4'd0) msb = 4'(i - 23);
    end
    pn = p >> msb;
    unique case (work.op)
      twd_pkg::OP_PASS: value = work.data;
      twd_pkg::OP_HALF: value = f;
      twd_pkg::OP_SCALE: begin
        if (e == 8'hFF) begin
          if (f[22:0] != 23'd0) value = f | 32'h0040_0000;
          else if (qmag == 8'd0) value = twd_pkg::QNanInf0;
          else value = {sgn, 31'd0} | twd_pkg::ExpAllOnes;
        end else if (e == 8'd0 || qmag == 8'd0) begin
          value = {sgn, 31'd0};
        end else begin
          value = {sgn, 8'(e + 8'(msb)), pn[22:0]};
        end
      end
      default: value = work.data;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/tensor_weight_dequantizer.sv */
// top level of the tensor weight dequantizer
//
//  channel  signals                               direction
//  in       in_valid in_stall data_byte tensor_start  byte words in
//  out      out_valid out_stall value_bits        binary32 words out
//  cfg      cfg_we cfg_wdata                      element_format register
//
// one byte word is taken per cycle while in_stall is low; the result word for the byte that
// completes it is registered and held in the output register
// the output register with a one-entry skid takes one more result word while output stalls
// rst (synchronous) clears position, gathered bytes, scale and format
// in_stall rises only when the skid entry holds a word
`default_nettype none
module tensor_weight_dequantizer (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_wdata,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic tensor_start,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [31:0] value_bits
);
  logic [1:0] element_format;
  logic take;
  logic emit;
  twd_pkg::work_t work;
  logic [31:0] value;
  logic skid_valid;
  logic [31:0] skid_bits;

  // input accepted whenever the skid slot is free
  assign in_stall = skid_valid;
  assign take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) element_format <= twd_pkg::FMT_F32;
    else if (cfg_we) element_format <= cfg_wdata;
  end

  twd_front u_front (
    .clk(clk), .rst(rst), .element_format(element_format), .take(take),
    .data_byte(data_byte), .tensor_start(tensor_start), .emit(emit), .work(work)
  );

  twd_math u_math (.work(work), .value(value));

  // output register plus skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && out_stall) begin
        if (take && emit) skid_valid <= 1'b1;
      end else begin
        if (skid_valid) begin
          out_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= take && emit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (take && emit) skid_bits <= value;
    end else if (skid_valid) begin
      value_bits <= skid_bits;
    end else if (take && emit) begin
      value_bits <= value;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid full with output empty");
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_stall |=> out_valid && !skid_valid) else $error("skid not drained");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value_bits)) else $error("output changed");
`endif
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// testbench for the tensor weight dequantizer: directed and random byte streams checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [7:0] data_byte;
  logic tensor_start;
  logic out_valid;
  logic out_stall;
  logic [31:0] value_bits;

  tensor_weight_dequantizer i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .tensor_start(tensor_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value_bits(value_bits)
  );

  // one pending input word: byte plus tensor start flag
  typedef struct packed {
    logic [7:0] b;
    logic start;
  } byte_word_t;

  byte_word_t pending_bytes[$];
  logic [31:0] expected_words[$];

  // predictor state
  twd_pkg::fmt_t pred_fmt;
  logic [5:0] pred_pos;
  logic [23:0] pred_partial;
  logic [15:0] pred_scale;

  int errors = 0;
  int cycle_count = 0;
  bit hold_start;   // long receiver hold-off request
  int hold_off;     // hold-off cycles left, counted by the receiver
  bit hold_started;

  // binary16 to binary32, exact, renormalizing subnormals
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] s;
    logic [4:0] e;
    logic [10:0] m;
    int sh;
    s = {h[15], 31'd0};
    e = h[14:10];
    m = {1'b0, h[9:0]};
    sh = 0;
    if (e == 5'd0) begin
      if (m == 11'd0) return s;
      while (!m[10] && sh < 11) begin
        m = m << 1;
        sh++;
      end
      return s | (32'(113 - sh) << 23) | (32'(m[9:0]) << 13);
    end
    if (e == 5'h1F) return s | 32'h7F80_0000 | (32'(m[9:0]) << 13);
    return s | (32'(e + 112) << 23) | (32'(m[9:0]) << 13);
  endfunction

  // exact product of a binary16 scale and a signed byte
  function automatic logic [31:0] scaled_weight(input logic [15:0] h, input logic [7:0] q);
    logic [31:0] f;
    logic [31:0] sign;
    logic [7:0] qmag;
    logic [8:0] e;
    logic [22:0] m;
    logic [63:0] p;
    f = widen_half(h);
    qmag = q[7] ? 8'(9'd256 - q) : q;
    sign = {f[31] ^ q[7], 31'd0};
    e = {1'b0, f[30:23]};
    m = f[22:0];
    if (e == 9'hFF) begin
      if (m != 0) return f | 32'h0040_0000;
      if (qmag == 0) return 32'hFFC0_0000;
      return sign | 32'h7F80_0000;
    end
    if (e == 0 || qmag == 0) return sign;
    p = 64'({1'b1, m}) * qmag;
    while (p >= 64'h100_0000) begin
      p = p >> 1;
      e++;
    end
    return sign | (32'(e[7:0]) << 23) | (32'(p) & 32'h7F_FFFF);
  endfunction

  // advance the predictor by one accepted byte
  task automatic predict_byte(input logic [7:0] b, input logic start);
    logic [5:0] pos;
    if (start) pred_pos = 6'd0;
    pos = pred_pos;
    case (pred_fmt)
      twd_pkg::FMT_F32: begin
        if (pos >= 4) pos = 6'd0;
        if (pos < 3) begin
          if (pos == 0) pred_partial = {16'd0, b};
          else pred_partial = pred_partial | (24'(b) << (8 * pos));
          pred_pos = pos + 6'd1;
        end else begin
          expected_words.push_back({b, pred_partial});
          pred_pos = 6'd0;
        end
      end
      twd_pkg::FMT_F16: begin
        if (pos >= 2) pos = 6'd0;
        if (pos == 0) begin
          pred_partial = {16'd0, b};
          pred_pos = 6'd1;
        end else begin
          expected_words.push_back(widen_half({b, pred_partial[7:0]}));
          pred_pos = 6'd0;
        end
      end
      twd_pkg::FMT_Q80: begin
        if (pos >= 34) pos = 6'd0;
        if (pos == 0) begin
          pred_partial = {16'd0, b};
          pred_pos = 6'd1;
        end else if (pos == 1) begin
          pred_scale = {b, pred_partial[7:0]};
          pred_pos = 6'd2;
        end else begin
          expected_words.push_back(scaled_weight(pred_scale, b));
          pred_pos = (pos + 1 >= 34) ? 6'd0 : pos + 6'd1;
        end
      end
      default: ;  // unused code: byte dropped
    endcase
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sender: one word per draw of a random gap, gaps sometimes off
  int send_gap;
  bit send_busy;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      data_byte <= 8'd0;
      tensor_start <= 1'b0;
      send_gap = 0;
      send_busy = 0;
      pred_pos = 6'd0;
      pred_partial = 24'd0;
      pred_scale = 16'd0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_byte(data_byte, tensor_start);
        send_busy = 0;
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      end
      if (!send_busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          byte_word_t w;
          w = pending_bytes.pop_front();
          data_byte <= w.b;
          tensor_start <= w.start;
          in_valid <= 1'b1;
          send_busy = 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus the long hold-off when asked
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_off = 0;
      hold_started = 0;
    end else begin
      if (hold_start && !hold_started) begin
        hold_off = 300;
        hold_started = 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected word: actual %h", $time, value_bits);
          errors++;
        end else begin
          logic [31:0] want;
          want = expected_words.pop_front();
          if (want !== value_bits) begin
            $display("%0t value_bits mismatch: expected %h actual %h", $time, want,
                     value_bits);
            errors++;
          end
        end
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      end
      if (hold_off > 0) begin
        hold_off--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 600000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic start);
    byte_word_t w;
    w.b = b;
    w.start = start;
    pending_bytes.push_back(w);
  endtask

  // let everything drain, then some spare cycles for dropped-byte work
  task automatic drain;
    while (pending_bytes.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic set_format(input twd_pkg::fmt_t f);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_we <= 1'b0;
    pred_fmt = f;
  endtask

  // a random binary16 value, biased toward the special exponents and zero mantissas
  function automatic logic [15:0] rand_half();
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(0, 5))
      0: h[14:10] = 5'h1F;
      1: h[14:10] = 5'h00;
      2: h[9:0] = 10'd0;
      default: ;
    endcase
    return h;
  endfunction

  task automatic q8_block(input logic start, input logic [15:0] scale);
    queue_byte(scale[7:0], start);
    queue_byte(scale[15:8], 1'b0);
    for (int i = 0; i < 32; i++) queue_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 2'd0;
    hold_start = 0;
    pred_fmt = twd_pkg::FMT_F32;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: binary32 extremes
    set_format(twd_pkg::FMT_F32);
    queue_byte(8'h00, 1'b1); queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0);
    // binary16: zero, subnormals, inf, NaN
    set_format(twd_pkg::FMT_F16);
    queue_byte(8'h00, 1'b1); queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b0); queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0); queue_byte(8'h03, 1'b0);
    queue_byte(8'h00, 1'b0); queue_byte(8'hFC, 1'b0);
    queue_byte(8'h01, 1'b0); queue_byte(8'h7E, 1'b0);
    // q8: NaN scale, inf scale with zero and nonzero q, zero times negative
    set_format(twd_pkg::FMT_Q80);
    queue_byte(8'h01, 1'b1); queue_byte(8'h7E, 1'b0);
    queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b1);
    queue_byte(8'h7C, 1'b0); queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b0); queue_byte(8'h7F, 1'b0);
    queue_byte(8'h00, 1'b1); queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    // unused code drops bytes; tensor start still clears position
    set_format(twd_pkg::FMT_NONE);
    queue_byte(8'hA5, 1'b1); queue_byte(8'h5A, 1'b0);

    // long receiver hold-off while the sender keeps offering bytes
    set_format(twd_pkg::FMT_F32);
    hold_start = 1;
    for (int i = 0; i < 40; i++) queue_byte(8'($urandom), i == 0);

    // random phases over all formats, each format change made after the stream drains
    for (int ph = 0; ph < 16; ph++) begin
      twd_pkg::fmt_t f;
      f = twd_pkg::fmt_t'($urandom_range(0, 3));
      set_format(f);
      if (f == twd_pkg::FMT_Q80) begin
        for (int k = 0; k < 3; k++) q8_block(1'($urandom_range(0, 1)), rand_half());
        for (int k = 0; k < 4; k++) queue_byte(8'($urandom), ($urandom_range(0, 15) == 0));
      end else begin
        int n;
        n = (f == twd_pkg::FMT_NONE) ? 10 : 100;
        for (int k = 0; k < n; k++) begin
          logic [7:0] b;
          b = 8'($urandom);
          if (f == twd_pkg::FMT_F16 && k % 2 == 1 && $urandom_range(0, 2) == 0)
            b[6:2] = $urandom_range(0, 1) ? 5'h1F : 5'h00;
          queue_byte(b, ($urandom_range(0, 19) == 0));
        end
      end
    end
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
